### rtl/text_console_glyph_renderer_defines.svh
// ---------------------------------------------------------------------------
// text console glyph renderer assertion macros
// same-cycle and next-cycle implication checks, empty under synthesis
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_GLYPH_RENDERER_DEFINES_SVH
`define TEXT_CONSOLE_GLYPH_RENDERER_DEFINES_SVH

`ifndef SYNTHESIS
`define TCGR_ASSERT_SAME(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("tcgr same-cycle check failed");
`define TCGR_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("tcgr next-cycle check failed");
`else
`define TCGR_ASSERT_SAME(label, clk, rst, cond, prop)
`define TCGR_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif

`endif

### rtl/tcgr_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcgr_pkg
// shared widths, codes, control word types and the microcode program
// ---------------------------------------------------------------------------
package tcgr_pkg;

  localparam int GLYPH_LINES = 16;
  localparam int FONT_BYTES  = 2048;

  localparam int LINE_W  = $clog2(GLYPH_LINES);
  localparam int FONT_AW = $clog2(FONT_BYTES);
  localparam int COL_W   = 10;
  localparam int ROW_W   = 8;
  localparam int SW_W    = 13;
  localparam int ADDR_W  = 24;
  localparam int BYTE_W  = 8;
  localparam int CODE_W  = 8;
  localparam int CH_W    = 7;
  localparam int FIN_W   = 11;
  localparam int ROWL_W  = ROW_W + LINE_W;
  localparam int IDX_W   = CH_W + LINE_W;
  localparam int CFG_W   = 13;
  localparam int CFG_IW  = 2;
  localparam int STEP_W  = 3;

  localparam logic [LINE_W-1:0] LINE_LAST = LINE_W'(GLYPH_LINES - 1);

  localparam logic [COL_W-1:0] TEXT_COLUMNS_RST = 10'd80;
  localparam logic [ROW_W-1:0] TEXT_ROWS_RST    = 8'd26;
  localparam logic [SW_W-1:0]  SCREEN_WIDTH_RST = 13'd640;

  localparam logic [CODE_W-1:0] CODE_NULL    = 8'd0;
  localparam logic [CODE_W-1:0] CODE_NEWLINE = 8'd10;
  localparam logic [CH_W-1:0]   CHAR_QMARK   = 7'd63;

  typedef enum logic [CFG_IW-1:0] {
    REG_TEXT_COLUMNS = 2'd0,
    REG_TEXT_ROWS    = 2'd1,
    REG_SCREEN_WIDTH = 2'd2
  } cfg_reg_t;

  typedef enum logic [0:0] {
    KIND_GLYPH  = 1'b0,
    KIND_SCROLL = 1'b1
  } out_kind_t;

  typedef enum logic [0:0] {
    MODE_CHAR = 1'b0,
    MODE_FONT = 1'b1
  } in_mode_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_CURSOR,
    OP_SCROLL,
    OP_GLYPH,
    OP_ADVANCE
  } ctl_op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ITEM,
    C_NO_SCROLL,
    C_NEWLINE,
    C_MORE_LINES
  } cond_t;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_IDLE    = 3'd0;
  localparam step_t STEP_CURSOR  = 3'd1;
  localparam step_t STEP_SCROLL  = 3'd2;
  localparam step_t STEP_NEWLINE = 3'd3;
  localparam step_t STEP_PREP    = 3'd4;
  localparam step_t STEP_GLYPH   = 3'd5;
  localparam step_t STEP_ADVANCE = 3'd6;

  typedef struct packed {
    ctl_op_t op;
    logic    take_in;
    logic    emit;
    cond_t   cond;
    step_t   target;
  } ctl_word_t;

  typedef struct packed {
    ctl_op_t op;
    logic    fire;
    logic    take_in;
  } seq_ctl_t;

  typedef struct packed {
    logic item_go;
    logic scroll;
    logic newline;
    logic more_lines;
    logic slot_free;
  } dp_stat_t;

  function automatic ctl_word_t ucode(input step_t step);
    ctl_word_t w;
    w = '{op: OP_NONE, take_in: 1'b0, emit: 1'b0, cond: C_ALWAYS, target: STEP_IDLE};
    case (step)
      STEP_IDLE: begin
        w = '{op: OP_LOAD, take_in: 1'b1, emit: 1'b0, cond: C_NO_ITEM, target: STEP_IDLE};
      end
      STEP_CURSOR: begin
        w = '{op: OP_CURSOR, take_in: 1'b0, emit: 1'b0, cond: C_NO_SCROLL,
              target: STEP_NEWLINE};
      end
      STEP_SCROLL: begin
        w = '{op: OP_SCROLL, take_in: 1'b0, emit: 1'b1, cond: C_NEVER, target: STEP_IDLE};
      end
      STEP_NEWLINE: begin
        w = '{op: OP_NONE, take_in: 1'b0, emit: 1'b0, cond: C_NEWLINE, target: STEP_IDLE};
      end
      STEP_PREP: begin
        w = '{op: OP_NONE, take_in: 1'b0, emit: 1'b0, cond: C_NEVER, target: STEP_IDLE};
      end
      STEP_GLYPH: begin
        w = '{op: OP_GLYPH, take_in: 1'b0, emit: 1'b1, cond: C_MORE_LINES,
              target: STEP_GLYPH};
      end
      STEP_ADVANCE: begin
        w = '{op: OP_ADVANCE, take_in: 1'b0, emit: 1'b0, cond: C_ALWAYS, target: STEP_IDLE};
      end
      default: begin
        w = '{op: OP_NONE, take_in: 1'b0, emit: 1'b0, cond: C_ALWAYS, target: STEP_IDLE};
      end
    endcase
    return w;
  endfunction

endpackage

### rtl/tcgr_sequencer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcgr_sequencer
// step counter over the microcode table with conditional jumps and stalls
// ---------------------------------------------------------------------------
module tcgr_sequencer (
  input  logic               clk,
  input  logic               rst,
  input  tcgr_pkg::dp_stat_t stat,
  output tcgr_pkg::seq_ctl_t ctl
);

  tcgr_pkg::step_t     step;
  tcgr_pkg::step_t     step_next;
  tcgr_pkg::ctl_word_t word;
  logic                go;
  logic                taken;

  always_comb begin
    word = tcgr_pkg::ucode(step);
    go   = !word.emit || stat.slot_free;
    case (word.cond)
      tcgr_pkg::C_NEVER:      taken = 1'b0;
      tcgr_pkg::C_ALWAYS:     taken = 1'b1;
      tcgr_pkg::C_NO_ITEM:    taken = !stat.item_go;
      tcgr_pkg::C_NO_SCROLL:  taken = !stat.scroll;
      tcgr_pkg::C_NEWLINE:    taken = stat.newline;
      tcgr_pkg::C_MORE_LINES: taken = stat.more_lines;
      default:                taken = 1'b1;
    endcase
    if (!go) begin
      step_next = step;
    end else if (taken) begin
      step_next = word.target;
    end else begin
      step_next = step + tcgr_pkg::STEP_W'(1);
    end
    ctl.op      = word.op;
    ctl.fire    = go;
    ctl.take_in = word.take_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= tcgr_pkg::STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

### rtl/tcgr_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcgr_datapath
// config registers, cursor, font store, address accumulator, output register
// ---------------------------------------------------------------------------
module tcgr_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  tcgr_pkg::seq_ctl_t                  ctl,
  output tcgr_pkg::dp_stat_t                  stat,
  input  logic                                cfg_write,
  input  logic [tcgr_pkg::CFG_IW-1:0]         cfg_index,
  input  logic [tcgr_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                in_valid,
  input  logic                                mode,
  input  logic [tcgr_pkg::CODE_W-1:0]         char_code,
  input  logic [tcgr_pkg::FIN_W-1:0]          font_address,
  input  logic [tcgr_pkg::BYTE_W-1:0]         font_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                kind,
  output logic [tcgr_pkg::ADDR_W-1:0]         pixel_address,
  output logic [tcgr_pkg::BYTE_W-1:0]         glyph_bits,
  output logic                                last
);

  localparam int PROD_W = tcgr_pkg::ROWL_W + tcgr_pkg::SW_W;

  logic [tcgr_pkg::COL_W-1:0]  text_columns;
  logic [tcgr_pkg::ROW_W-1:0]  text_rows;
  logic [tcgr_pkg::SW_W-1:0]   screen_width;
  logic [tcgr_pkg::COL_W-1:0]  cursor_column;
  logic [tcgr_pkg::ROW_W-1:0]  cursor_row;
  logic [tcgr_pkg::CH_W-1:0]   ch;
  logic                        is_newline;
  logic [tcgr_pkg::LINE_W-1:0] line;
  logic [tcgr_pkg::LINE_W-1:0] line_next;
  logic [tcgr_pkg::ADDR_W-1:0] row_base;
  logic [tcgr_pkg::ADDR_W-1:0] pixel_acc;
  logic [tcgr_pkg::BYTE_W-1:0] rd_byte;
  logic [tcgr_pkg::BYTE_W-1:0] font_store [tcgr_pkg::FONT_BYTES];

  logic [tcgr_pkg::COL_W-1:0]  cols_eff;
  logic [tcgr_pkg::ROW_W-1:0]  rows_eff;
  logic                        wrap;
  logic [tcgr_pkg::ROW_W:0]    row_step;
  logic                        row_hit;
  logic [tcgr_pkg::ROW_W-1:0]  row_after;
  logic [tcgr_pkg::ROWL_W-1:0] row_lines;
  logic [PROD_W-1:0]           prod_full;
  logic [tcgr_pkg::IDX_W-1:0]  font_index;
  logic                        slot_free;
  logic                        accept;
  logic                        emit_now;
  logic                        glyph_go;

  always_comb begin
    cols_eff  = (text_columns == '0) ? tcgr_pkg::COL_W'(1) : text_columns;
    rows_eff  = (text_rows == '0) ? tcgr_pkg::ROW_W'(1) : text_rows;
    wrap      = is_newline || (cursor_column >= cols_eff);
    row_step  = {1'b0, cursor_row} + {{tcgr_pkg::ROW_W{1'b0}}, wrap};
    row_hit   = row_step >= {1'b0, rows_eff};
    row_after = row_hit ? (rows_eff - tcgr_pkg::ROW_W'(1)) : row_step[tcgr_pkg::ROW_W-1:0];

    slot_free = !out_valid || out_ready;
    accept    = (ctl.op == tcgr_pkg::OP_LOAD) && ctl.fire && in_valid;
    glyph_go  = (ctl.op == tcgr_pkg::OP_GLYPH) && ctl.fire;
    emit_now  = ctl.fire && ((ctl.op == tcgr_pkg::OP_SCROLL) || glyph_go);

    if (ctl.op != tcgr_pkg::OP_GLYPH) begin
      line_next = '0;
    end else if (glyph_go) begin
      line_next = (line == tcgr_pkg::LINE_LAST) ? '0 : line + tcgr_pkg::LINE_W'(1);
    end else begin
      line_next = line;
    end

    font_index = tcgr_pkg::IDX_W'(ch) * tcgr_pkg::IDX_W'(tcgr_pkg::GLYPH_LINES)
               + tcgr_pkg::IDX_W'(line_next);
    row_lines  = tcgr_pkg::ROWL_W'(cursor_row) * tcgr_pkg::ROWL_W'(tcgr_pkg::GLYPH_LINES);
    prod_full  = {{tcgr_pkg::SW_W{1'b0}}, row_lines} * {{tcgr_pkg::ROWL_W{1'b0}}, screen_width};

    stat.item_go    = in_valid && (mode == tcgr_pkg::MODE_CHAR) && (char_code != tcgr_pkg::CODE_NULL);
    stat.scroll     = row_hit;
    stat.newline    = is_newline;
    stat.more_lines = line != tcgr_pkg::LINE_LAST;
    stat.slot_free  = slot_free;
  end

  // configuration and cursor
  always_ff @(posedge clk) begin
    if (rst) begin
      text_columns  <= tcgr_pkg::TEXT_COLUMNS_RST;
      text_rows     <= tcgr_pkg::TEXT_ROWS_RST;
      screen_width  <= tcgr_pkg::SCREEN_WIDTH_RST;
      cursor_column <= '0;
      cursor_row    <= '0;
      line          <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          tcgr_pkg::REG_TEXT_COLUMNS: text_columns <= cfg_data[tcgr_pkg::COL_W-1:0];
          tcgr_pkg::REG_TEXT_ROWS:    text_rows    <= cfg_data[tcgr_pkg::ROW_W-1:0];
          tcgr_pkg::REG_SCREEN_WIDTH: screen_width <= cfg_data[tcgr_pkg::SW_W-1:0];
          default: ;
        endcase
      end
      if (ctl.fire && (ctl.op == tcgr_pkg::OP_CURSOR)) begin
        cursor_row <= row_after;
        if (wrap) begin
          cursor_column <= '0;
        end
      end
      if (ctl.fire && (ctl.op == tcgr_pkg::OP_ADVANCE)) begin
        cursor_column <= cursor_column + tcgr_pkg::COL_W'(1);
      end
      line <= line_next;
    end
  end

  // item latch and address arithmetic
  always_ff @(posedge clk) begin
    if (accept) begin
      ch         <= char_code[tcgr_pkg::CODE_W-1] ? tcgr_pkg::CHAR_QMARK
                                                   : char_code[tcgr_pkg::CH_W-1:0];
      is_newline <= char_code == tcgr_pkg::CODE_NEWLINE;
    end
    row_base <= tcgr_pkg::ADDR_W'(prod_full);
    if (glyph_go) begin
      pixel_acc <= pixel_acc + tcgr_pkg::ADDR_W'(screen_width);
    end else if (ctl.op != tcgr_pkg::OP_GLYPH) begin
      pixel_acc <= row_base + (tcgr_pkg::ADDR_W'(cursor_column) << 3);
    end
  end

  // font store
  always_ff @(posedge clk) begin
    if (accept && (mode == tcgr_pkg::MODE_FONT)) begin
      font_store[tcgr_pkg::FONT_AW'(font_address)] <= font_byte;
    end
    rd_byte <= font_store[tcgr_pkg::FONT_AW'(font_index)];
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_now) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_now) begin
      if (glyph_go) begin
        kind          <= tcgr_pkg::KIND_GLYPH;
        pixel_address <= pixel_acc;
        glyph_bits    <= rd_byte;
        last          <= line == tcgr_pkg::LINE_LAST;
      end else begin
        kind          <= tcgr_pkg::KIND_SCROLL;
        pixel_address <= '0;
        glyph_bits    <= '0;
        last          <= is_newline;
      end
    end
  end

endmodule

### rtl/text_console_glyph_renderer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// text_console_glyph_renderer
// text console character renderer with font store and scroll command
// ---------------------------------------------------------------------------
// A font byte write or a null character stays in the accept step. A newline
// passes the accept, cursor update and newline test steps, plus the scroll step
// when it scrolls. A printable character also passes the microcode glyph step,
// which issues one row word per cycle while the output register has room, over
// 16 glyph lines, reading the font store one byte ahead, with four fixed steps
// around it (accept, cursor update, newline test, address setup) and one for the
// column advance; the scroll step waits for room too. The font store holds no
// reset value; load a glyph before printing it.
`include "text_console_glyph_renderer_defines.svh"

module text_console_glyph_renderer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [tcgr_pkg::CFG_IW-1:0] cfg_index,
  input  logic [tcgr_pkg::CFG_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        mode,
  input  logic [tcgr_pkg::CODE_W-1:0] char_code,
  input  logic [tcgr_pkg::FIN_W-1:0]  font_address,
  input  logic [tcgr_pkg::BYTE_W-1:0] font_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        kind,
  output logic [tcgr_pkg::ADDR_W-1:0] pixel_address,
  output logic [tcgr_pkg::BYTE_W-1:0] glyph_bits,
  output logic                        last
);

  tcgr_pkg::seq_ctl_t ctl;
  tcgr_pkg::dp_stat_t stat;

  tcgr_sequencer u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctl  (ctl)
  );

  tcgr_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .stat          (stat),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .mode          (mode),
    .char_code     (char_code),
    .font_address  (font_address),
    .font_byte     (font_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .pixel_address (pixel_address),
    .glyph_bits    (glyph_bits),
    .last          (last)
  );

  assign in_ready = ctl.take_in;

  // a waiting word at the next accept is always the end of the previous item
  `TCGR_ASSERT_SAME(a_idle_pending_last, clk, rst, in_ready && out_valid, last)
  // a character item leaves the accept step
  `TCGR_ASSERT_NEXT(a_char_leaves_idle, clk, rst,
    in_valid && in_ready && !mode && (char_code != tcgr_pkg::CODE_NULL), !in_ready)
  // font writes and null characters return at once
  `TCGR_ASSERT_NEXT(a_quiet_item_stays, clk, rst,
    in_valid && in_ready && (mode || (char_code == tcgr_pkg::CODE_NULL)), in_ready)

endmodule

### dv/text_console_glyph_renderer_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// text_console_glyph_renderer_test
// Self-checking bench for the text console glyph renderer. It loads glyphs
// into the font store and prints characters, newlines, null and high codes
// under several console geometries, the extreme ones among them. A predictor
// tracks the font store, the cursor and the registers, and every output word
// is checked against the oldest expected word. Both handshakes idle at random.
// ---------------------------------------------------------------------------
module text_console_glyph_renderer_test;
  import tcgr_pkg::*;

  typedef struct packed {
    out_kind_t           kind;
    logic [ADDR_W-1:0]   addr;
    logic [BYTE_W-1:0]   bits;
    logic                last;
  } glyph_row_t;

  typedef enum logic {ROW_WORD, ROW_REG} row_op_t;

  typedef struct packed {
    row_op_t             op;
    cfg_reg_t            sel;
    logic [CFG_W-1:0]    val;
    in_mode_t            mode;
    logic [CODE_W-1:0]   code;
    logic [FIN_W-1:0]    faddr;
    logic [BYTE_W-1:0]   fbyte;
    logic                chk;
    logic [4:0]          n_res;
    out_kind_t           k0;
    logic [ADDR_W-1:0]   a0;
  } stim_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_HALF, RX_SPARSE, RX_TOGGLE} rx_pat_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_write = 1'b0;
  logic [CFG_IW-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]    cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                mode = 1'b0;
  logic [CODE_W-1:0]   char_code = '0;
  logic [FIN_W-1:0]    font_address = '0;
  logic [BYTE_W-1:0]   font_byte = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                kind;
  logic [ADDR_W-1:0]   pixel_address;
  logic [BYTE_W-1:0]   glyph_bits;
  logic                last;

  // predictor state
  logic [BYTE_W-1:0]   font_img [FONT_BYTES];
  logic                font_known [FONT_BYTES];
  logic [COL_W-1:0]    cur_col = '0;
  int unsigned         cur_row = 0;
  logic [COL_W-1:0]    set_cols = TEXT_COLUMNS_RST;
  logic [ROW_W-1:0]    set_rows = TEXT_ROWS_RST;
  logic [SW_W-1:0]     set_width = SCREEN_WIDTH_RST;

  glyph_row_t          exp_rows [$];
  stim_row_t           dir_tbl [$];
  int                  fail_count = 0;
  int                  rows_taken = 0;
  int                  burst_left = 0;
  bit                  valid_up = 0;
  int                  hold_left = 0;
  bit                  hold_done = 0;
  int                  pat_left = 0;
  rx_pat_t             pat_sel = RX_OPEN;

  text_console_glyph_renderer DUT (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .char_code(char_code), .font_address(font_address), .font_byte(font_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .pixel_address(pixel_address), .glyph_bits(glyph_bits), .last(last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("FAIL text_console_glyph_renderer");
    $finish;
  end

  task automatic report_miss(input string what, input longint unsigned got,
                             input longint unsigned want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    fail_count++;
  endtask

  task automatic render_word(input in_mode_t m, input logic [CODE_W-1:0] c,
                             input logic [FIN_W-1:0] a, input logic [BYTE_W-1:0] b,
                             output int n, output glyph_row_t first);
    logic [CH_W-1:0] glyph;
    logic            nl;
    logic            scroll;
    int unsigned     cols;
    int unsigned     rows;
    int unsigned     pa;
    int              j;
    glyph_row_t      r;
    n = 0;
    first = '0;
    if (m == MODE_FONT) begin
      font_img[a] = b;
      font_known[a] = 1'b1;
    end else if (c != CODE_NULL) begin
      glyph = c[7] ? CHAR_QMARK : c[CH_W-1:0];
      nl = (c == CODE_NEWLINE);
      cols = (set_cols == 0) ? 1 : set_cols;
      rows = (set_rows == 0) ? 1 : set_rows;
      if (nl || cur_col >= cols) begin
        cur_col = '0;
        cur_row = cur_row + 1;
      end
      scroll = 1'b0;
      if (cur_row >= rows) begin
        cur_row = rows - 1;
        scroll = 1'b1;
      end
      if (scroll) begin
        r = '{kind: KIND_SCROLL, addr: '0, bits: '0, last: nl};
        exp_rows.push_back(r);
        first = r;
        n = 1;
      end
      if (!nl) begin
        for (j = 0; j < GLYPH_LINES; j++) begin
          pa = (cur_row * GLYPH_LINES + j) * 32'(set_width) + 32'(cur_col) * 8;
          r = '{kind: KIND_GLYPH, addr: pa[ADDR_W-1:0],
                bits: font_img[{glyph, j[LINE_W-1:0]}], last: (j == GLYPH_LINES - 1)};
          exp_rows.push_back(r);
          if (n == 0) first = r;
          n++;
        end
        cur_col = cur_col + 1'b1;
      end
    end
  endtask

  task automatic send_word(input in_mode_t m, input logic [CODE_W-1:0] c,
                           input logic [FIN_W-1:0] a, input logic [BYTE_W-1:0] b,
                           output int n, output glyph_row_t first);
    int gap;
    if (burst_left == 0) burst_left = $urandom_range(1, 12);
    in_valid <= 1'b1;
    mode <= m;
    char_code <= c;
    font_address <= a;
    font_byte <= b;
    valid_up = 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    render_word(m, c, a, b, n, first);
    burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        valid_up = 0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic push_word(input in_mode_t m, input logic [CODE_W-1:0] c,
                           input logic [FIN_W-1:0] a, input logic [BYTE_W-1:0] b);
    int         n;
    glyph_row_t first;
    send_word(m, c, a, b, n, first);
  endtask

  task automatic drop_valid();
    if (valid_up) begin
      in_valid <= 1'b0;
      valid_up = 0;
    end
    burst_left = 0;
  endtask

  // all words out, then room for a font write or null still in flight
  task automatic settle();
    drop_valid();
    while (exp_rows.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t sel, input logic [CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= sel;
    cfg_data <= val;
    @(posedge clk);
    case (sel)
      REG_TEXT_COLUMNS: set_cols = val[COL_W-1:0];
      REG_TEXT_ROWS:    set_rows = val[ROW_W-1:0];
      default:          set_width = val[SW_W-1:0];
    endcase
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_glyph(input logic [CH_W-1:0] ch);
    int j;
    for (j = 0; j < GLYPH_LINES; j++) begin
      if (!font_known[{ch, j[LINE_W-1:0]}])
        push_word(MODE_FONT, CODE_W'($urandom), {ch, j[LINE_W-1:0]}, BYTE_W'($urandom));
    end
  endtask

  // characters from the preloaded glyph set
  task automatic print_random_char();
    logic [CODE_W-1:0] c;
    case ($urandom_range(0, 3))
      0:       c = 8'd1;
      1:       c = {1'b0, CHAR_QMARK};
      2:       c = 8'd65;
      default: c = 8'd127;
    endcase
    load_glyph(c[CH_W-1:0]);
    push_word(MODE_CHAR, c, FIN_W'($urandom), BYTE_W'($urandom));
  endtask

  task automatic pick_settings(input bit deep);
    logic [CFG_W-1:0] v;
    settle();
    case ($urandom_range(0, 5))
      0: v = 0;
      1: v = 1;
      2: v = CFG_W'($urandom_range(2, 4));
      3: v = CFG_W'($urandom_range(1, 512));
      4: v = 1023;
      default: v = 80;
    endcase
    write_reg(REG_TEXT_COLUMNS, v);
    case ($urandom_range(0, 5))
      0: v = 0;
      1: v = 1;
      2: v = CFG_W'($urandom_range(2, 4));
      3: v = CFG_W'($urandom_range(1, 255));
      4: v = 255;
      default: v = 26;
    endcase
    if (deep) v = 255;
    write_reg(REG_TEXT_ROWS, v);
    case ($urandom_range(0, 5))
      0: v = 0;
      1: v = 8;
      2: v = CFG_W'($urandom_range(8, 4096));
      3: v = 4096;
      4: v = 8191;
      default: v = 640;
    endcase
    if (deep) v = 8191;
    write_reg(REG_SCREEN_WIDTH, v);
  endtask

  function automatic stim_row_t word_row(input in_mode_t m, input logic [CODE_W-1:0] c,
                                         input logic [FIN_W-1:0] a,
                                         input logic [BYTE_W-1:0] b, input logic chk,
                                         input logic [4:0] n, input out_kind_t k0,
                                         input logic [ADDR_W-1:0] a0);
    stim_row_t r;
    r = '0;
    r.op = ROW_WORD;
    r.mode = m;
    r.code = c;
    r.faddr = a;
    r.fbyte = b;
    r.chk = chk;
    r.n_res = n;
    r.k0 = k0;
    r.a0 = a0;
    return r;
  endfunction

  function automatic stim_row_t reg_row(input cfg_reg_t sel, input logic [CFG_W-1:0] val);
    stim_row_t r;
    r = '0;
    r.op = ROW_REG;
    r.sel = sel;
    r.val = val;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && rows_taken >= 400) begin
      hold_done <= 1'b1;
      hold_left <= 500;
      out_ready <= 1'b0;
    end else begin
      if (pat_left == 0) begin
        pat_sel <= rx_pat_t'($urandom_range(0, 3));
        pat_left <= $urandom_range(4, 60);
      end else begin
        pat_left <= pat_left - 1;
      end
      case (pat_sel)
        RX_OPEN:   out_ready <= 1'b1;
        RX_HALF:   out_ready <= ($urandom_range(0, 1) == 0);
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:   out_ready <= ~out_ready;
      endcase
    end
  end

  always @(posedge clk) begin : watch_out
    glyph_row_t want;
    if (!rst && out_valid && out_ready) begin
      rows_taken <= rows_taken + 1;
      if (exp_rows.size() == 0) begin
        report_miss("unexpected word", pixel_address, 0);
      end else begin
        want = exp_rows.pop_front();
        if (kind !== want.kind) report_miss("kind", kind, want.kind);
        if (pixel_address !== want.addr) report_miss("pixel_address", pixel_address, want.addr);
        if (glyph_bits !== want.bits) report_miss("glyph_bits", glyph_bits, want.bits);
        if (last !== want.last) report_miss("last", last, want.last);
      end
    end
  end

  initial begin
    int         i;
    int         k;
    int         p;
    int         n;
    int         sel;
    glyph_row_t first;

    foreach (font_known[a]) begin
      font_known[a] = 1'b0;
      font_img[a] = '0;
    end

    // sanity rows at reset geometry, then the limit and extreme geometries
    dir_tbl.push_back(word_row(MODE_FONT, 8'd0, 11'd0, 8'hFF, 1, 0, KIND_GLYPH, 0));
    dir_tbl.push_back(word_row(MODE_FONT, 8'hFF, 11'd2047, 8'h81, 1, 0, KIND_GLYPH, 0));
    dir_tbl.push_back(word_row(MODE_CHAR, CODE_NULL, 11'h7FF, 8'hFF, 1, 0, KIND_GLYPH, 0));
    dir_tbl.push_back(word_row(MODE_CHAR, 8'd65, 0, 0, 1, 16, KIND_GLYPH, 0));
    dir_tbl.push_back(word_row(MODE_CHAR, 8'd1, 0, 0, 1, 16, KIND_GLYPH, 8));
    dir_tbl.push_back(word_row(MODE_CHAR, 8'd127, 0, 0, 1, 16, KIND_GLYPH, 16));
    dir_tbl.push_back(word_row(MODE_CHAR, 8'd128, 0, 0, 1, 16, KIND_GLYPH, 24));
    dir_tbl.push_back(word_row(MODE_CHAR, 8'd255, 0, 0, 1, 16, KIND_GLYPH, 32));
    dir_tbl.push_back(word_row(MODE_CHAR, CODE_NEWLINE, 0, 0, 1, 0, KIND_GLYPH, 0));
    dir_tbl.push_back(word_row(MODE_CHAR, 8'd65, 0, 0, 1, 16, KIND_GLYPH, 10240));
    dir_tbl.push_back(reg_row(REG_TEXT_COLUMNS, 1));
    dir_tbl.push_back(reg_row(REG_TEXT_ROWS, 1));
    dir_tbl.push_back(word_row(MODE_CHAR, 8'd65, 0, 0, 1, 17, KIND_SCROLL, 0));
    dir_tbl.push_back(word_row(MODE_CHAR, CODE_NEWLINE, 0, 0, 1, 1, KIND_SCROLL, 0));
    dir_tbl.push_back(reg_row(REG_TEXT_COLUMNS, 0));
    dir_tbl.push_back(reg_row(REG_TEXT_ROWS, 0));
    dir_tbl.push_back(reg_row(REG_SCREEN_WIDTH, 0));
    dir_tbl.push_back(word_row(MODE_CHAR, 8'd63, 0, 0, 1, 16, KIND_GLYPH, 0));
    dir_tbl.push_back(word_row(MODE_CHAR, 8'd200, 0, 0, 1, 17, KIND_SCROLL, 0));
    dir_tbl.push_back(reg_row(REG_TEXT_COLUMNS, 1023));
    dir_tbl.push_back(reg_row(REG_TEXT_ROWS, 255));
    dir_tbl.push_back(reg_row(REG_SCREEN_WIDTH, 8191));
    dir_tbl.push_back(word_row(MODE_CHAR, 8'd127, 0, 0, 1, 16, KIND_GLYPH, 8));
    dir_tbl.push_back(word_row(MODE_CHAR, CODE_NEWLINE, 0, 0, 1, 0, KIND_GLYPH, 0));
    dir_tbl.push_back(word_row(MODE_CHAR, 8'd65, 0, 0, 1, 16, KIND_GLYPH, 131056));
    dir_tbl.push_back(reg_row(REG_TEXT_COLUMNS, 512));
    dir_tbl.push_back(reg_row(REG_SCREEN_WIDTH, 4096));
    dir_tbl.push_back(word_row(MODE_CHAR, 8'd255, 11'h555, 8'hAA, 0, 0, KIND_GLYPH, 0));
    dir_tbl.push_back(word_row(MODE_CHAR, 8'd65, 11'h2AA, 8'h55, 0, 0, KIND_GLYPH, 0));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // glyphs used by the directed rows
    load_glyph(7'd1);
    load_glyph(CHAR_QMARK);
    load_glyph(7'd65);
    load_glyph(7'd127);

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].op == ROW_REG) begin
        settle();
        write_reg(dir_tbl[i].sel, dir_tbl[i].val);
      end else begin
        send_word(dir_tbl[i].mode, dir_tbl[i].code, dir_tbl[i].faddr, dir_tbl[i].fbyte,
                  n, first);
        if (dir_tbl[i].chk) begin
          if (n != dir_tbl[i].n_res)
            report_miss($sformatf("result count, row %0d", i), n, dir_tbl[i].n_res);
          else if (n != 0 && (first.kind != dir_tbl[i].k0 || first.addr != dir_tbl[i].a0))
            report_miss($sformatf("first word, row %0d", i), first, {dir_tbl[i].k0,
                        dir_tbl[i].a0});
        end
      end
    end

    for (p = 0; p < 3; p++) begin
      pick_settings(p == 1);
      i = 0;
      while (i < 20) begin
        sel = $urandom_range(0, 99);
        if (sel < 10) begin
          push_word(MODE_FONT, CODE_W'($urandom), FIN_W'($urandom), BYTE_W'($urandom));
          i++;
        end else if (sel < 15) begin
          push_word(MODE_CHAR, CODE_NULL, FIN_W'($urandom), BYTE_W'($urandom));
        end else if (sel < 30) begin
          push_word(MODE_CHAR, CODE_NEWLINE, FIN_W'($urandom), BYTE_W'($urandom));
          i++;
        end else if (sel < 40) begin
          push_word(MODE_CHAR, CODE_W'($urandom_range(128, 255)), FIN_W'($urandom),
                    BYTE_W'($urandom));
          i++;
        end else begin
          print_random_char();
          i++;
        end
      end
    end

    drop_valid();
    for (k = 0; k < 50000 && exp_rows.size() != 0; k++) @(posedge clk);
    repeat (40) @(posedge clk);
    if (exp_rows.size() != 0) report_miss("words missing", exp_rows.size(), 0);
    if (fail_count == 0) begin
      $display("PASS text_console_glyph_renderer");
    end else begin
      $display("FAIL text_console_glyph_renderer");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/tcgr_pkg.sv
rtl/tcgr_sequencer.sv
rtl/tcgr_datapath.sv
rtl/text_console_glyph_renderer.sv
dv/text_console_glyph_renderer_test.sv
